// ===== rtl/first_fit_heap_allocator_assert.svh =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator assertion macros
// shared immediate-cause and next-cycle property forms, clocked on clk
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define FFHA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ffha check failed");

// next-cycle implication
`define FFHA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ffha check failed");

`endif

// ===== rtl/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// ffha_pkg
// shared types and constants of the first-fit heap allocator
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int unsigned CFG_W      = 13;
  localparam int unsigned MIN_HEAP   = 32;
  localparam int unsigned HEAP_RESET = 4096;
  localparam int unsigned REQ_W      = 12;
  localparam int unsigned ALIGN_W    = 9;
  localparam int unsigned OFS_W      = 12;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic [REQ_W-1:0]   request_bytes;
    logic [ALIGN_W-1:0] align_bytes;
    logic [OFS_W-1:0]   release_offset;
  } ffha_item_t;

  typedef struct packed {
    logic             ok;
    logic [OFS_W-1:0] payload_offset;
    logic [OFS_W-1:0] granted_bytes;
  } ffha_res_t;

  typedef struct packed {
    logic idle;
    logic fmt_ack;
    logic res_valid;
  } ffha_stat_t;

endpackage

// ===== rtl/ffha_in_if.sv =====
// ----------------------------------------------------------------------------
// ffha_in_if
// request channel: valid/ready with alloc and free fields
// ----------------------------------------------------------------------------
interface ffha_in_if;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [ffha_pkg::REQ_W-1:0]    request_bytes;
  logic [ffha_pkg::ALIGN_W-1:0]  align_bytes;
  logic [ffha_pkg::OFS_W-1:0]    release_offset;

  modport source (output valid, opcode, request_bytes, align_bytes, release_offset,
                  input ready);
  modport sink (input valid, opcode, request_bytes, align_bytes, release_offset,
                output ready);
endinterface

// ===== rtl/ffha_out_if.sv =====
// ----------------------------------------------------------------------------
// ffha_out_if
// result channel: valid/ready with grant fields
// ----------------------------------------------------------------------------
interface ffha_out_if;
  logic                        valid;
  logic                        ready;
  logic                        ok;
  logic [ffha_pkg::OFS_W-1:0]  payload_offset;
  logic [ffha_pkg::OFS_W-1:0]  granted_bytes;

  modport source (output valid, ok, payload_offset, granted_bytes, input ready);
  modport sink (input valid, ok, payload_offset, granted_bytes, output ready);
endinterface

// ===== rtl/ffha_ram.sv =====
// ----------------------------------------------------------------------------
// ffha_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module ffha_ram #(
  parameter int unsigned WIDTH = 14,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/ffha_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffha_ctrl
// header walk sequencer: alloc first-fit with split, free with coalescing
// ----------------------------------------------------------------------------
`include "first_fit_heap_allocator_assert.svh"

module ffha_ctrl #(
  parameter int unsigned HEAP_MAX_BYTES = 4096,
  parameter int unsigned HEADER_BYTES   = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start_i,
  input  ffha_pkg::ffha_item_t               item_i,
  input  logic [$clog2(HEAP_MAX_BYTES):0]    heap_i,
  input  logic                               fmt_req_i,
  input  logic                               res_free_i,
  output ffha_pkg::ffha_stat_t               stat_o,
  output ffha_pkg::ffha_res_t                res_o
);

  localparam int unsigned AW = $clog2(HEAP_MAX_BYTES);
  localparam int unsigned SW = AW + 1;
  localparam int unsigned DW = SW + 1;
  localparam int unsigned XW = ((SW > 13) ? SW : 13) + 2;
  localparam logic [XW-1:0] HDR_X = XW'(HEADER_BYTES);

  typedef enum logic [2:0] {
    S_IDLE, S_ACHK, S_ASPLIT, S_FMARK, S_CSTART, S_CA, S_CB, S_RESP
  } state_t;

  state_t              state_r, state_nxt;
  logic [AW-1:0]       off_r, off_nxt;
  logic [AW-1:0]       bofs_r, bofs_nxt;
  logic [XW-1:0]       size_r, size_nxt;
  logic [SW-1:0]       a_size_r, a_size_nxt;
  logic                a_free_r, a_free_nxt;
  ffha_pkg::ffha_res_t res_r, res_nxt;

  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [DW-1:0]       mem_wdata;
  logic [AW-1:0]       mem_raddr;
  logic [DW-1:0]       mem_rdata;

  logic                rd_free;
  logic [SW-1:0]       rd_size;
  logic [XW-1:0]       cur_x, heap_x, off_x, bofs_x, walk_x, rel_x, rel_hdr;
  logic [XW-1:0]       round_x, split_x, merged_x, next_x;
  logic [ffha_pkg::ALIGN_W-1:0] amask;

  ffha_ram #(.WIDTH(DW), .DEPTH(HEAP_MAX_BYTES)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign rd_free = mem_rdata[SW];
  assign rd_size = mem_rdata[SW-1:0];
  assign cur_x   = XW'(rd_size);
  assign heap_x  = XW'(heap_i);
  assign off_x   = XW'(off_r);
  assign bofs_x  = XW'(bofs_r);
  assign walk_x  = off_x + HDR_X + cur_x;
  assign rel_x   = XW'(item_i.release_offset);
  assign rel_hdr = rel_x - HDR_X;
  assign split_x = off_x + HDR_X + size_r;

  // alignment mask from the highest set bit, zero counts as one
  always_comb begin
    amask = '0;
    for (int i = 1; i < int'(ffha_pkg::ALIGN_W); i++) begin
      if (item_i.align_bytes[i]) begin
        amask = ffha_pkg::ALIGN_W'((1 << i) - 1);
      end
    end
  end

  assign round_x = (XW'(item_i.request_bytes) + XW'(amask)) & ~XW'(amask);

  always_comb begin
    state_nxt  = state_r;
    off_nxt    = off_r;
    bofs_nxt   = bofs_r;
    size_nxt   = size_r;
    a_size_nxt = a_size_r;
    a_free_nxt = a_free_r;
    res_nxt    = res_r;
    mem_we     = 1'b0;
    mem_waddr  = off_r;
    mem_wdata  = '0;
    mem_raddr  = off_r;
    merged_x   = '0;
    next_x     = '0;
    unique case (state_r)
      S_IDLE: begin
        if (fmt_req_i) begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = {1'b1, SW'(heap_x - HDR_X)};
        end else if (start_i) begin
          res_nxt  = '0;
          size_nxt = round_x;
          off_nxt  = '0;
          if (item_i.opcode == ffha_pkg::OP_ALLOC) begin
            mem_raddr = '0;
            state_nxt = S_ACHK;
          end else if ((rel_x >= HDR_X) && (rel_hdr < heap_x)) begin
            mem_raddr = rel_hdr[AW-1:0];
            off_nxt   = rel_hdr[AW-1:0];
            state_nxt = S_FMARK;
          end else begin
            state_nxt = S_CSTART;
          end
        end
      end
      S_ACHK: begin
        if (rd_free && (cur_x >= size_r)) begin
          mem_we = 1'b1;
          if (cur_x > size_r + HDR_X) begin
            mem_waddr = split_x[AW-1:0];
            mem_wdata = {1'b1, SW'(cur_x - size_r - HDR_X)};
            state_nxt = S_ASPLIT;
          end else begin
            mem_wdata = {1'b0, rd_size};
            res_nxt.ok             = 1'b1;
            res_nxt.payload_offset = ffha_pkg::OFS_W'(off_x + HDR_X);
            res_nxt.granted_bytes  = ffha_pkg::OFS_W'(cur_x);
            state_nxt = S_RESP;
          end
        end else if (walk_x >= heap_x) begin
          state_nxt = S_RESP;
        end else begin
          off_nxt   = walk_x[AW-1:0];
          mem_raddr = walk_x[AW-1:0];
        end
      end
      S_ASPLIT: begin
        mem_we    = 1'b1;
        mem_wdata = {1'b0, SW'(size_r)};
        res_nxt.ok             = 1'b1;
        res_nxt.payload_offset = ffha_pkg::OFS_W'(off_x + HDR_X);
        res_nxt.granted_bytes  = ffha_pkg::OFS_W'(size_r);
        state_nxt = S_RESP;
      end
      S_FMARK: begin
        mem_we    = 1'b1;
        mem_wdata = {1'b1, rd_size};
        state_nxt = S_CSTART;
      end
      S_CSTART: begin
        mem_raddr = '0;
        off_nxt   = '0;
        state_nxt = S_CA;
      end
      S_CA: begin
        a_size_nxt = rd_size;
        a_free_nxt = rd_free;
        if (walk_x >= heap_x) begin
          res_nxt.ok = 1'b1;
          state_nxt  = S_RESP;
        end else begin
          bofs_nxt  = walk_x[AW-1:0];
          mem_raddr = walk_x[AW-1:0];
          state_nxt = S_CB;
        end
      end
      S_CB: begin
        if (a_free_r && rd_free) begin
          merged_x   = XW'(a_size_r) + cur_x + HDR_X;
          a_size_nxt = SW'(merged_x);
          mem_we     = 1'b1;
          mem_wdata  = {1'b1, SW'(merged_x)};
          next_x     = off_x + HDR_X + merged_x;
        end else begin
          off_nxt    = bofs_r;
          a_size_nxt = rd_size;
          a_free_nxt = rd_free;
          next_x     = bofs_x + HDR_X + cur_x;
        end
        if (next_x >= heap_x) begin
          res_nxt.ok = 1'b1;
          state_nxt  = S_RESP;
        end else begin
          bofs_nxt  = next_x[AW-1:0];
          mem_raddr = next_x[AW-1:0];
        end
      end
      S_RESP: begin
        if (res_free_i) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    off_r    <= off_nxt;
    bofs_r   <= bofs_nxt;
    size_r   <= size_nxt;
    a_size_r <= a_size_nxt;
    a_free_r <= a_free_nxt;
    res_r    <= res_nxt;
  end

  assign stat_o.idle      = (state_r == S_IDLE);
  assign stat_o.fmt_ack   = (state_r == S_IDLE) && fmt_req_i;
  assign stat_o.res_valid = (state_r == S_RESP);
  assign res_o            = res_r;

  `FFHA_ASSERT_IMP(a_wr_in_heap, mem_we, ({1'b0, mem_waddr} < heap_i))
  `FFHA_ASSERT_IMP(a_start_idle, start_i, (state_r == S_IDLE) && !fmt_req_i)
  `FFHA_ASSERT_IMP(a_fail_zero, (state_r == S_RESP) && !res_r.ok,
                   (res_r.payload_offset == '0) && (res_r.granted_bytes == '0))

endmodule

// ===== rtl/first_fit_heap_allocator.sv =====
// alloc: first-fit header walk from entry 0, then a header write for a split
// free: marks a valid released block free, then a coalescing walk over headers
// one item at a time; each block costs one read of the header ram
// result sits in an output register; the next request is taken once it is loaded
// reset and each heap size write format the heap once the controller is idle (entry 0 written)
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// first-fit heap manager with block split and free-block coalescing
// ----------------------------------------------------------------------------
module first_fit_heap_allocator #(
  parameter int unsigned HEAP_MAX_BYTES = 4096,
  parameter int unsigned HEADER_BYTES   = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  ffha_in_if.sink                     in_chan,
  ffha_out_if.source                  out_chan,
  input  logic                        cfg_we,
  input  logic [ffha_pkg::CFG_W-1:0]  cfg_data
);

  localparam int unsigned HW = $clog2(HEAP_MAX_BYTES) + 1;
  localparam int unsigned CW = ((HW > ffha_pkg::CFG_W) ? HW : ffha_pkg::CFG_W) + 1;
  localparam int unsigned RESET_HEAP =
    (ffha_pkg::HEAP_RESET > HEAP_MAX_BYTES) ? HEAP_MAX_BYTES : ffha_pkg::HEAP_RESET;

  logic [HW-1:0]        heap_r, heap_nxt;
  logic                 fmt_pend_r, fmt_pend_nxt;
  logic                 out_valid_r, out_valid_nxt;
  ffha_pkg::ffha_res_t  out_res_r, out_res_nxt;
  ffha_pkg::ffha_stat_t stat;
  ffha_pkg::ffha_res_t  res;
  ffha_pkg::ffha_item_t item;
  logic [CW-1:0]        cfg_x;
  logic                 start;
  logic                 res_free;

  assign cfg_x = CW'(cfg_data);

  always_comb begin
    priority if (cfg_x < CW'(ffha_pkg::MIN_HEAP)) begin
      heap_nxt = HW'(ffha_pkg::MIN_HEAP);
    end else if (cfg_x > CW'(HEAP_MAX_BYTES)) begin
      heap_nxt = HW'(HEAP_MAX_BYTES);
    end else begin
      heap_nxt = cfg_x[HW-1:0];
    end
  end

  assign item.opcode         = in_chan.opcode;
  assign item.request_bytes  = in_chan.request_bytes;
  assign item.align_bytes    = in_chan.align_bytes;
  assign item.release_offset = in_chan.release_offset;

  assign in_chan.ready = stat.idle && !fmt_pend_r;
  assign start         = in_chan.valid && in_chan.ready;
  assign res_free      = !out_valid_r || out_chan.ready;

  ffha_ctrl #(
    .HEAP_MAX_BYTES (HEAP_MAX_BYTES),
    .HEADER_BYTES   (HEADER_BYTES)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (start),
    .item_i     (item),
    .heap_i     (heap_r),
    .fmt_req_i  (fmt_pend_r),
    .res_free_i (res_free),
    .stat_o     (stat),
    .res_o      (res)
  );

  assign fmt_pend_nxt  = cfg_we || (fmt_pend_r && !stat.fmt_ack);
  assign out_valid_nxt = (stat.res_valid && res_free) || (out_valid_r && !out_chan.ready);
  assign out_res_nxt   = (stat.res_valid && res_free) ? res : out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_r      <= HW'(RESET_HEAP);
      fmt_pend_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        heap_r <= heap_nxt;
      end
      fmt_pend_r  <= fmt_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_res_r <= out_res_nxt;
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.ok             = out_res_r.ok;
  assign out_chan.payload_offset = out_res_r.payload_offset;
  assign out_chan.granted_bytes  = out_res_r.granted_bytes;

endmodule

// ===== tb/sv/ffha_test_pkg.sv =====
// ----------------------------------------------------------------------------
// ffha_test_pkg
// heap allocator model for first_fit_heap_allocator_test: first-fit with split
// and coalescing, kept as header and free-mark arrays
// ----------------------------------------------------------------------------
package ffha_test_pkg;
  import ffha_pkg::*;

  localparam int unsigned HEAP_MAX = 4096;
  localparam int unsigned HDR      = 16;

  typedef struct {
    int unsigned total_bytes;
    int unsigned size_at[HEAP_MAX];
    bit          free_at[HEAP_MAX];
  } heap_image_t;

  function automatic void format_heap(ref heap_image_t h, input int unsigned bytes);
    int unsigned v;
    v = bytes & 13'h1fff;
    if (v < MIN_HEAP) v = MIN_HEAP;
    if (v > HEAP_MAX) v = HEAP_MAX;
    h.total_bytes = v;
    h.size_at[0] = v - HDR;
    h.free_at[0] = 1'b1;
  endfunction

  function automatic int unsigned round_to_align(int unsigned req, int unsigned al);
    int unsigned a;
    a = 1;
    while ((a << 1) <= al) a = a << 1;
    return (req + a - 1) & ~(a - 1);
  endfunction

  function automatic ffha_res_t heap_step(ref heap_image_t h, input ffha_item_t it);
    ffha_res_t   r;
    int unsigned sz, ofs, cur, nxt;
    r = '0;
    if (it.opcode == OP_ALLOC) begin
      sz = round_to_align(it.request_bytes, it.align_bytes);
      ofs = 0;
      while (ofs < h.total_bytes) begin
        cur = h.size_at[ofs];
        if (h.free_at[ofs] && cur >= sz) begin
          if (cur > sz + HDR) begin
            h.size_at[ofs + HDR + sz] = cur - sz - HDR;
            h.free_at[ofs + HDR + sz] = 1'b1;
            h.size_at[ofs] = sz;
          end
          h.free_at[ofs] = 1'b0;
          r.ok = 1'b1;
          r.payload_offset = OFS_W'(ofs + HDR);
          r.granted_bytes = OFS_W'(h.size_at[ofs]);
          return r;
        end
        ofs += HDR + cur;
      end
      return r;
    end
    if (it.release_offset >= HDR && it.release_offset - HDR < h.total_bytes)
      h.free_at[it.release_offset - HDR] = 1'b1;
    ofs = 0;
    while (ofs < h.total_bytes) begin
      nxt = ofs + HDR + h.size_at[ofs];
      if (nxt >= h.total_bytes) break;
      if (h.free_at[ofs] && h.free_at[nxt]) h.size_at[ofs] += h.size_at[nxt] + HDR;
      else ofs = nxt;
    end
    r.ok = 1'b1;
    return r;
  endfunction
endpackage

// ===== tb/sv/first_fit_heap_allocator_test.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_test
// drives alloc/free mixes over several heap sizes with random idling on both
// channels, predicts every result with a heap model and compares each transfer
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_test;
  import ffha_pkg::*;
  import ffha_test_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;

  ffha_in_if  req_if();
  ffha_out_if res_if();

  first_fit_heap_allocator dut (
    .clk(clk), .rst_n(rst_n), .in_chan(req_if.sink), .out_chan(res_if.source),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  heap_image_t heap;
  ffha_item_t  pending_reqs[$];
  ffha_res_t   expected_grants[$];
  int unsigned live_offsets[$];
  int          errors = 0;
  bit          calm = 1'b0;
  int          send_gap = 0;
  int          recv_stall = 0;
  int          quiet_cycles = 0;

  initial begin
    req_if.valid = 1'b0;
    req_if.opcode = OP_ALLOC;
    req_if.request_bytes = '0;
    req_if.align_bytes = 9'd1;
    req_if.release_offset = '0;
    res_if.ready = 1'b0;
  end

  // driver
  always @(posedge clk) begin
    if (req_if.valid && req_if.ready) begin
      expected_grants.push_back(heap_step(heap, ffha_item_t'({req_if.opcode,
        req_if.request_bytes, req_if.align_bytes, req_if.release_offset})));
    end
    if (!req_if.valid || req_if.ready) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        req_if.valid <= 1'b0;
      end else if (pending_reqs.size() > 0 && rst_n) begin
        req_if.valid <= 1'b1;
        req_if.opcode <= pending_reqs[0].opcode;
        req_if.request_bytes <= pending_reqs[0].request_bytes;
        req_if.align_bytes <= pending_reqs[0].align_bytes;
        req_if.release_offset <= pending_reqs[0].release_offset;
        void'(pending_reqs.pop_front());
        if (!calm && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 14);
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    ffha_res_t got, want;
    if (res_if.valid && res_if.ready) begin
      got = '{res_if.ok, res_if.payload_offset, res_if.granted_bytes};
      if (expected_grants.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = expected_grants.pop_front();
        if (got !== want) begin
          $display("%0t: result mismatch expected ok=%0d ofs=%0d size=%0d",
                   $time, want.ok, want.payload_offset, want.granted_bytes,
                   " actual ok=%0d ofs=%0d size=%0d",
                   got.ok, got.payload_offset, got.granted_bytes);
          errors++;
        end
      end
    end
    if (recv_stall > 0) begin
      recv_stall <= recv_stall - 1;
      res_if.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      recv_stall <= $urandom_range(0, 13);
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 40000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int unsigned pow2_align();
    return 1 << $urandom_range(0, 8);
  endfunction

  task automatic queue_alloc(int unsigned req, int unsigned al);
    ffha_item_t it;
    it = '0;
    it.opcode = OP_ALLOC;
    it.request_bytes = REQ_W'(req);
    it.align_bytes = ALIGN_W'(al);
    it.release_offset = OFS_W'($urandom);
    pending_reqs.push_back(it);
  endtask

  task automatic queue_free(int unsigned rel);
    ffha_item_t it;
    it = '0;
    it.opcode = OP_FREE;
    it.release_offset = OFS_W'(rel);
    it.request_bytes = REQ_W'($urandom);
    it.align_bytes = ALIGN_W'($urandom);
    pending_reqs.push_back(it);
  endtask

  task automatic drain();
    wait (pending_reqs.size() == 0 && !req_if.valid && expected_grants.size() == 0);
    repeat (4200) @(posedge clk);
  endtask

  task automatic set_heap(int unsigned bytes);
    drain();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= CFG_W'(bytes);
    format_heap(heap, bytes);
    live_offsets.delete();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // random phase: most frees take offsets of allocated blocks, so they hit real blocks; some use random offsets
  task automatic random_phase(int n, int unsigned max_req);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0)
        queue_free($urandom);
      else if (live_offsets.size() > 0 && $urandom_range(0, 2) == 0) begin
        int k;
        k = $urandom_range(0, live_offsets.size() - 1);
        queue_free(live_offsets[k]);
        live_offsets.delete(k);
      end else begin
        queue_alloc($urandom_range(0, max_req),
                    $urandom_range(0, 7) == 0 ? $urandom_range(0, 511) : pow2_align());
      end
      // refresh live offsets after each short batch
      if (i % 16 == 15 || i == n - 1) begin
        drain_light();
      end
    end
  endtask

  // collect granted offsets after each short batch
  task automatic drain_light();
    wait (pending_reqs.size() == 0 && !req_if.valid && expected_grants.size() == 0);
    live_offsets.delete();
    for (int unsigned ofs = 0; ofs < heap.total_bytes; ofs += HDR + heap.size_at[ofs])
      if (!heap.free_at[ofs]) live_offsets.push_back(ofs + HDR);
  endtask

  initial begin
    format_heap(heap, HEAP_RESET);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    queue_alloc(0, 1);
    queue_alloc(12'hfff, 9'h100);
    queue_alloc(100, 0);
    queue_alloc(33, 9'd24);
    queue_alloc(7, 9'h1ff);
    queue_alloc(0, 9'h100);
    queue_alloc(12'hfff, 1);
    queue_free(16);
    queue_free(16);
    queue_free(0);
    queue_free(12'hfff);
    queue_free(21);
    queue_alloc(4000, 1);
    queue_alloc(4095 - 16, 1);
    queue_alloc(4095 - 15, 1);
    queue_alloc(1, 9'h80);
    queue_free(16);
    queue_alloc(12'h555, 9'h0aa);
    queue_alloc(12'haaa, 9'h155);
    drain_light();

    random_phase(350, 600);
    set_heap(32);
    queue_alloc(16, 1);
    queue_alloc(0, 1);
    queue_free(32);
    queue_alloc(17, 1);
    random_phase(60, 40);
    set_heap(13'h1fff);
    random_phase(350, 300);
    set_heap(5);
    random_phase(60, 60);
    set_heap(4096);
    random_phase(300, 900);
    set_heap(700);
    random_phase(300, 120);
    set_heap(13'h0aaa);
    random_phase(150, 200);
    calm = 1'b1;
    random_phase(150, 400);

    wait (pending_reqs.size() == 0 && !req_if.valid && expected_grants.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule
